// File: sv/bbc_pkg.sv
// shared types and constants of the bollinger band calculator
package bbc_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int MULT_W    = 8;
    localparam int MULT_FRAC = 4;

    localparam logic [CFG_IDX_W-1:0] REG_BAND_MULT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd1;

    localparam logic [MULT_W-1:0] MULT_RESET = 8'd24;
    localparam int WLEN_RESET = 5;
    localparam int WLEN_MIN   = 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_WSQ_GO,
        S_WSQ_WAIT,
        S_SS_GO,
        S_SS_WAIT,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_VAR_GO,
        S_VAR_WAIT,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_BAND,
        S_DONE
    } t_state;

endpackage

// File: sv/bbc_if.sv
// channel interfaces: price input, band result output, configuration writes
interface bbc_in_if #(parameter int PRICE_BITS = 24);
    logic                  valid;
    logic                  ready;
    logic [PRICE_BITS-1:0] price;
    modport source(output valid, output price, input ready);
    modport sink(input valid, input price, output ready);
endinterface

interface bbc_out_if #(parameter int PRICE_BITS = 24);
    logic                         valid;
    logic                         ready;
    logic                         window_full;
    logic        [PRICE_BITS-1:0] window_mean;
    logic        [PRICE_BITS-1:0] upper_band;
    logic signed [PRICE_BITS:0]   lower_band;
    modport source(output valid, output window_full, output window_mean,
                   output upper_band, output lower_band, input ready);
    modport sink(input valid, input window_full, input window_mean,
                 input upper_band, input lower_band, output ready);
endinterface

interface bbc_cfg_if #(parameter int DATA_W = 8);
    import bbc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// File: sv/bbc_ram.sv
// generic single write port ram with registered read
module bbc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// File: sv/bbc_mul.sv
// shift-add multiplier, one multiplier bit per cycle
module bbc_mul #(
    parameter int A_W = 53,
    parameter int B_W = 30
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [A_W-1:0]   i_a,
    input  logic [B_W-1:0]   i_b,
    output logic             o_done,
    output logic [A_W+B_W-1:0] o_product
);
    localparam int P_W = A_W + B_W;
    localparam int C_W = $clog2(B_W + 1);

    logic           r_busy;
    logic           r_done;
    logic [C_W-1:0] r_cnt;
    logic [P_W-1:0] r_a;
    logic [B_W-1:0] r_b;
    logic [P_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == C_W'(B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= P_W'(i_a);
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;
endmodule

// File: sv/bbc_div.sv
// restoring divider, one quotient bit per cycle
module bbc_div #(
    parameter int N_W = 59,
    parameter int D_W = 12
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic           o_done,
    output logic [N_W-1:0] o_quotient
);
    localparam int C_W = $clog2(N_W + 1);

    logic           r_busy;
    logic           r_done;
    logic [C_W-1:0] r_cnt;
    logic [N_W-1:0] r_num;
    logic [D_W-1:0] r_den;
    logic [D_W-1:0] r_rem;
    logic [D_W:0]   w_rem_sh;
    logic [D_W:0]   w_rem_sub;
    logic           w_ge;

    assign w_rem_sh  = {r_rem, r_num[N_W-1]};
    assign w_ge      = w_rem_sh >= {1'b0, r_den};
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == C_W'(N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_rem_sub[D_W-1:0] : w_rem_sh[D_W-1:0];
            r_num <= {r_num[N_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_num;
endmodule

// File: sv/bbc_isqrt.sv
// integer square root, one result bit per cycle
module bbc_isqrt #(
    parameter int X_W = 59
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [X_W-1:0]         i_x,
    output logic                   o_done,
    output logic [(X_W+1)/2-1:0]   o_root
);
    localparam int E_W = X_W + (X_W % 2);
    localparam int R_W = E_W / 2;
    localparam int C_W = $clog2(R_W + 1);

    logic           r_busy;
    logic           r_done;
    logic [C_W-1:0] r_cnt;
    logic [E_W-1:0] r_x;
    logic [E_W-1:0] r_res;
    logic [E_W-1:0] r_bit;
    logic [E_W-1:0] w_trial;

    assign w_trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == C_W'(R_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= E_W'(i_x);
            r_res <= '0;
            r_bit <= E_W'(1) << (E_W - 2);
        end else if (r_busy) begin
            if (r_x >= w_trial) begin
                r_x   <= r_x - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[R_W-1:0];
endmodule

// File: sv/bollinger_band_calculator.sv
// bollinger band calculator top level: sample ring, running sums, band sequencer
// One price item is taken at a time. The item reads the oldest sample from the
// sample ring memory, squares both samples, updates the running sum and running
// square sum and writes the new sample back. Until window_length samples are
// held, the result is all zeros with window_full low. Once the window is full,
// the variance numerator W*SQ - S*S is formed in two passes on a shift-add
// multiplier, the mean and the variance come from two passes on one shared
// restoring divider and the deviation from a bit-serial square root. A new item
// is taken once the previous one has reached the output register, even if that
// result is still waiting. Writing window_length restarts the window; writing
// band_multiplier keeps it.
module bollinger_band_calculator #(
    parameter int WINDOW_MAX = 32,
    parameter int PRICE_BITS = 24
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bbc_in_if.sink    i_price_ch,
    bbc_out_if.source o_result_ch,
    bbc_cfg_if.sink   i_cfg_ch
);
    import bbc_pkg::*;

    localparam int CNT_W    = $clog2(WINDOW_MAX + 1);
    localparam int SLOT_W   = $clog2(WINDOW_MAX);
    localparam int CFG_W    = (CNT_W > MULT_W) ? CNT_W : MULT_W;
    localparam int SUM_W    = PRICE_BITS + CNT_W;
    localparam int PSQ_W    = 2 * PRICE_BITS;
    localparam int SQ_W     = PSQ_W + CNT_W;
    localparam int PROD_W   = SQ_W + SUM_W;
    localparam int DIFF_W   = SQ_W + CNT_W;
    localparam int DEN_W    = 2 * CNT_W;
    localparam int SD_W     = (DIFF_W + 1) / 2;
    localparam int DPROD_W  = MULT_W + SD_W;
    localparam int DEV_W    = DPROD_W - MULT_FRAC;
    localparam int EXT_W    = DEV_W + 1;

    // state and configuration
    t_state              r_state, n_state;
    logic [MULT_W-1:0]   r_mult;
    logic [CNT_W-1:0]    r_wlen;
    logic [SLOT_W-1:0]   r_slot;
    logic [CNT_W-1:0]    r_fill;
    logic [SUM_W-1:0]    r_sum;
    logic [SQ_W-1:0]     r_sq;

    // per item working registers
    logic [PRICE_BITS-1:0] r_price;
    logic [SLOT_W-1:0]     r_cur_slot;
    logic [PRICE_BITS-1:0] r_old;
    logic [PSQ_W-1:0]      r_old_sq;
    logic [PSQ_W-1:0]      r_new_sq;
    logic                  r_win_full;
    logic [DIFF_W-1:0]     r_lhs;
    logic [DIFF_W-1:0]     r_diff;
    logic [PRICE_BITS-1:0] r_mean;
    logic [DEV_W-1:0]      r_dev;

    // output register
    logic                  r_out_valid;
    logic                  r_out_full;
    logic [PRICE_BITS-1:0] r_out_mean;
    logic [PRICE_BITS-1:0] r_out_upper;
    logic [PRICE_BITS:0]   r_out_lower;

    // sequencer outputs
    logic in_ready;
    logic ram_rd_en;
    logic ram_wr_en;
    logic mul_start;
    logic div_start;
    logic sqrt_start;
    logic out_load;

    logic                  in_accept;
    logic                  cfg_accept;
    logic [SLOT_W-1:0]     w_slot;
    logic [PRICE_BITS-1:0] w_ram_rd;
    logic                  w_full_before;
    logic [CNT_W-1:0]      w_fill_after;
    logic                  w_full_now;
    logic [CNT_W-1:0]      w_cfg_wlen;

    logic [SQ_W-1:0]       w_mul_a;
    logic [SUM_W-1:0]      w_mul_b;
    logic                  w_mul_done;
    logic [PROD_W-1:0]     w_mul_prod;
    logic [DIFF_W-1:0]     w_div_num;
    logic [DEN_W-1:0]      w_div_den;
    logic                  w_div_done;
    logic [DIFF_W-1:0]     w_div_quo;
    logic                  w_sqrt_done;
    logic [SD_W-1:0]       w_sd;
    logic [DPROD_W-1:0]    w_dev_prod;

    logic [EXT_W-1:0]      w_mean_x;
    logic [EXT_W-1:0]      w_dev_x;
    logic [EXT_W-1:0]      w_upper_sum;
    logic [EXT_W-1:0]      w_lower_pos;
    logic [EXT_W-1:0]      w_mag;
    logic [EXT_W-1:0]      w_mag_cl;
    logic [PRICE_BITS-1:0] w_upper;
    logic [PRICE_BITS:0]   w_lower;

    assign in_accept  = i_price_ch.valid && in_ready;
    assign cfg_accept = i_cfg_ch.valid;
    assign i_price_ch.ready = in_ready;
    assign i_cfg_ch.ready   = 1'b1;

    // write slot wraps if the window shrank below it
    assign w_slot = (CNT_W'(r_slot) >= r_wlen) ? '0 : r_slot;

    assign w_full_before = r_fill >= r_wlen;
    assign w_fill_after  = w_full_before ? r_wlen : r_fill + 1'b1;
    assign w_full_now    = w_fill_after >= r_wlen;

    // window length written below the minimum or above the ring size is clamped
    always_comb begin
        if (i_cfg_ch.data < CFG_W'(WLEN_MIN)) begin
            w_cfg_wlen = CNT_W'(WLEN_MIN);
        end else if (i_cfg_ch.data > CFG_W'(WINDOW_MAX)) begin
            w_cfg_wlen = CNT_W'(WINDOW_MAX);
        end else begin
            w_cfg_wlen = i_cfg_ch.data[CNT_W-1:0];
        end
    end

    // sample ring
    bbc_ram #(
        .WIDTH(PRICE_BITS),
        .DEPTH(WINDOW_MAX)
    ) u_ring (
        .i_clk    (i_clk),
        .i_wr_en  (ram_wr_en),
        .i_wr_addr(r_cur_slot),
        .i_wr_data(r_price),
        .i_rd_en  (ram_rd_en),
        .i_rd_addr(w_slot),
        .o_rd_data(w_ram_rd)
    );

    // shared multiplier: W*SQ first, then S*S
    assign w_mul_a = (r_state == S_WSQ_GO) ? r_sq : SQ_W'(r_sum);
    assign w_mul_b = (r_state == S_WSQ_GO) ? SUM_W'(r_wlen) : r_sum;

    bbc_mul #(
        .A_W(SQ_W),
        .B_W(SUM_W)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_a      (w_mul_a),
        .i_b      (w_mul_b),
        .o_done   (w_mul_done),
        .o_product(w_mul_prod)
    );

    // shared divider: sum / W for the mean, numerator / (W*(W-1)) for the variance
    assign w_div_num = (r_state == S_MEAN_GO) ? DIFF_W'(r_sum) : r_diff;
    assign w_div_den = (r_state == S_MEAN_GO) ? DEN_W'(r_wlen)
                                              : DEN_W'(r_wlen) * DEN_W'(r_wlen - 1'b1);

    bbc_div #(
        .N_W(DIFF_W),
        .D_W(DEN_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_num     (w_div_num),
        .i_den     (w_div_den),
        .o_done    (w_div_done),
        .o_quotient(w_div_quo)
    );

    bbc_isqrt #(
        .X_W(DIFF_W)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(sqrt_start),
        .i_x    (w_div_quo),
        .o_done (w_sqrt_done),
        .o_root (w_sd)
    );

    assign w_dev_prod = DPROD_W'(r_mult) * DPROD_W'(w_sd);

    // band arithmetic with saturation
    assign w_mean_x    = EXT_W'(r_mean);
    assign w_dev_x     = EXT_W'(r_dev);
    assign w_upper_sum = w_mean_x + w_dev_x;
    assign w_lower_pos = w_mean_x - w_dev_x;
    assign w_mag       = w_dev_x - w_mean_x;
    assign w_mag_cl    = (w_mag > (EXT_W'(1) << PRICE_BITS)) ? (EXT_W'(1) << PRICE_BITS) : w_mag;

    always_comb begin
        if (w_upper_sum > EXT_W'({PRICE_BITS{1'b1}})) begin
            w_upper = {PRICE_BITS{1'b1}};
        end else begin
            w_upper = w_upper_sum[PRICE_BITS-1:0];
        end
        if (w_dev_x <= w_mean_x) begin
            w_lower = w_lower_pos[PRICE_BITS:0];
        end else begin
            w_lower = (~w_mag_cl[PRICE_BITS:0]) + 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                n_state = w_full_now ? S_WSQ_GO : S_DONE;
            end
            S_WSQ_GO: begin
                n_state = S_WSQ_WAIT;
            end
            S_WSQ_WAIT: begin
                if (w_mul_done) begin
                    n_state = S_SS_GO;
                end
            end
            S_SS_GO: begin
                n_state = S_SS_WAIT;
            end
            S_SS_WAIT: begin
                if (w_mul_done) begin
                    n_state = S_MEAN_GO;
                end
            end
            S_MEAN_GO: begin
                n_state = S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
                if (w_div_done) begin
                    n_state = S_VAR_GO;
                end
            end
            S_VAR_GO: begin
                n_state = S_VAR_WAIT;
            end
            S_VAR_WAIT: begin
                if (w_div_done) begin
                    n_state = S_SQRT_GO;
                end
            end
            S_SQRT_GO: begin
                n_state = S_SQRT_WAIT;
            end
            S_SQRT_WAIT: begin
                if (w_sqrt_done) begin
                    n_state = S_BAND;
                end
            end
            S_BAND: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_result_ch.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        in_ready   = 1'b0;
        ram_rd_en  = 1'b0;
        ram_wr_en  = 1'b0;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                in_ready  = 1'b1;
                ram_rd_en = i_price_ch.valid;
            end
            S_UPDATE: begin
                ram_wr_en = 1'b1;
            end
            S_WSQ_GO, S_SS_GO: begin
                mul_start = 1'b1;
            end
            S_MEAN_GO, S_VAR_GO: begin
                div_start = 1'b1;
            end
            S_SQRT_GO: begin
                sqrt_start = 1'b1;
            end
            S_DONE: begin
                out_load = !r_out_valid || o_result_ch.ready;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mult      <= MULT_RESET;
            r_wlen      <= CNT_W'(WLEN_RESET);
            r_slot      <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_sq        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_accept && i_cfg_ch.index == REG_BAND_MULT) begin
                r_mult <= i_cfg_ch.data[MULT_W-1:0];
            end
            if (cfg_accept && i_cfg_ch.index == REG_WINDOW_LEN) begin
                // restart the window
                r_wlen <= w_cfg_wlen;
                r_slot <= '0;
                r_fill <= '0;
                r_sum  <= '0;
                r_sq   <= '0;
            end else if (r_state == S_UPDATE) begin
                if (w_full_before) begin
                    r_sum <= r_sum - SUM_W'(r_old) + SUM_W'(r_price);
                    r_sq  <= r_sq - SQ_W'(r_old_sq) + SQ_W'(r_new_sq);
                end else begin
                    r_sum <= r_sum + SUM_W'(r_price);
                    r_sq  <= r_sq + SQ_W'(r_new_sq);
                end
                r_fill <= w_fill_after;
                r_slot <= (CNT_W'(r_cur_slot) + 1'b1 >= r_wlen) ? '0 : r_cur_slot + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_price    <= i_price_ch.price;
            r_cur_slot <= w_slot;
        end
        if (r_state == S_READ) begin
            r_old    <= w_ram_rd;
            r_old_sq <= PSQ_W'(w_ram_rd) * PSQ_W'(w_ram_rd);
            r_new_sq <= PSQ_W'(r_price) * PSQ_W'(r_price);
        end
        if (r_state == S_UPDATE) begin
            r_win_full <= w_full_now;
        end
        if (r_state == S_WSQ_WAIT && w_mul_done) begin
            r_lhs <= w_mul_prod[DIFF_W-1:0];
        end
        if (r_state == S_SS_WAIT && w_mul_done) begin
            r_diff <= r_lhs - w_mul_prod[DIFF_W-1:0];
        end
        if (r_state == S_MEAN_WAIT && w_div_done) begin
            r_mean <= w_div_quo[PRICE_BITS-1:0];
        end
        if (r_state == S_BAND) begin
            r_dev <= w_dev_prod[DPROD_W-1:MULT_FRAC];
        end
        if (out_load) begin
            r_out_full <= r_win_full;
            if (r_win_full) begin
                r_out_mean  <= r_mean;
                r_out_upper <= w_upper;
                r_out_lower <= w_lower;
            end else begin
                r_out_mean  <= '0;
                r_out_upper <= '0;
                r_out_lower <= '0;
            end
        end
    end

    assign o_result_ch.valid       = r_out_valid;
    assign o_result_ch.window_full = r_out_full;
    assign o_result_ch.window_mean = r_out_mean;
    assign o_result_ch.upper_band  = r_out_upper;
    assign o_result_ch.lower_band  = r_out_lower;
endmodule

// File: sim/bollinger_band_calculator_tb.sv
// self-checking testbench of the bollinger band calculator
`timescale 1ns / 100ps

module bollinger_band_calculator_tb;
    import bbc_pkg::*;

    localparam int WMAX  = 32;
    localparam int PBITS = 24;

    typedef struct packed {
        logic                    window_full;
        logic [PBITS-1:0]        window_mean;
        logic [PBITS-1:0]        upper_band;
        logic signed [PBITS:0]   lower_band;
    } t_band_result;

    logic clk;
    logic rst_n;

    bbc_in_if  #(.PRICE_BITS(PBITS)) price_ch ();
    bbc_out_if #(.PRICE_BITS(PBITS)) result_ch ();
    bbc_cfg_if #(.DATA_W(8))         cfg_ch ();

    bollinger_band_calculator #(
        .WINDOW_MAX(WMAX),
        .PRICE_BITS(PBITS)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_price_ch (price_ch),
        .o_result_ch(result_ch),
        .i_cfg_ch   (cfg_ch)
    );

    // prices waiting for the driver and bands waiting for the dut
    logic [PBITS-1:0] pending_prices[$];
    t_band_result     expected_bands[$];
    int               fails;

    // idle percentages of sender and receiver, set per phase
    int  tx_idle_pct;
    int  rx_idle_pct;
    // long receiver hold-off, requested by the stimulus, counted down by the receiver
    logic hold_req;
    logic hold_taken;
    int   hold_left;

    // shadow of the window state and registers
    logic [PBITS-1:0]  ring_shadow[WMAX];
    int                slot_shadow;
    int                fill_shadow;
    longint unsigned   sum_shadow;
    longint unsigned   sqsum_shadow;
    logic [7:0]        mult_shadow;
    int                wlen_shadow;

    function automatic void restart_shadow();
        slot_shadow  = 0;
        fill_shadow  = 0;
        sum_shadow   = 0;
        sqsum_shadow = 0;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x    = x - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // push one price into the shadow window and work out its bands
    function automatic t_band_result predict_bands(logic [PBITS-1:0] price);
        t_band_result    res;
        int              slot;
        longint unsigned old;
        longint unsigned w;
        logic [127:0]    num;
        longint unsigned variance;
        longint unsigned dev;
        longint unsigned mean;
        longint unsigned upper;
        longint unsigned mag;
        w    = wlen_shadow;
        slot = (slot_shadow >= wlen_shadow) ? 0 : slot_shadow;
        if (fill_shadow >= wlen_shadow) begin
            // full window: the oldest sample leaves the sums
            old          = ring_shadow[slot];
            sum_shadow   = sum_shadow - old;
            sqsum_shadow = sqsum_shadow - old * old;
            fill_shadow  = wlen_shadow;
        end else begin
            fill_shadow++;
        end
        ring_shadow[slot] = price;
        sum_shadow        = sum_shadow + price;
        sqsum_shadow      = sqsum_shadow + longint'(price) * longint'(price);
        slot_shadow       = (slot + 1 >= wlen_shadow) ? 0 : slot + 1;
        res = '0;
        if (fill_shadow < wlen_shadow) return res;
        mean     = sum_shadow / w;
        num      = 128'(w) * 128'(sqsum_shadow) - 128'(sum_shadow) * 128'(sum_shadow);
        variance = 64'(num / 128'(w * (w - 1)));
        dev      = (longint'(mult_shadow) * int_sqrt(variance)) >> 4;
        upper    = mean + dev;
        if (upper > 64'hFF_FFFF) upper = 64'hFF_FFFF;
        res.window_full = 1'b1;
        res.window_mean = mean[PBITS-1:0];
        res.upper_band  = upper[PBITS-1:0];
        if (dev <= mean) begin
            res.lower_band = (PBITS+1)'(mean - dev);
        end else begin
            // negative lower band, clamped at the signed minimum
            mag = dev - mean;
            if (mag > (64'd1 << PBITS)) mag = 64'd1 << PBITS;
            res.lower_band = (PBITS+1)'(64'd0 - mag);
        end
        return res;
    endfunction

    // clock
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // price driver: next item only when the slot is empty or was just taken
    always @(posedge clk) begin
        if (!rst_n) begin
            price_ch.valid <= 1'b0;
        end else if (!price_ch.valid || price_ch.ready) begin
            if (pending_prices.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                price_ch.valid <= 1'b1;
                price_ch.price <= pending_prices.pop_front();
            end else begin
                price_ch.valid <= 1'b0;
            end
        end
    end

    // accepted items and register writes update the shadow state
    always @(posedge clk) begin
        if (rst_n) begin
            if (price_ch.valid && price_ch.ready)
                expected_bands.push_back(predict_bands(price_ch.price));
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.index == REG_BAND_MULT) begin
                    mult_shadow = cfg_ch.data;
                end else if (cfg_ch.index == REG_WINDOW_LEN) begin
                    // out-of-range lengths clamp, every write restarts the window
                    wlen_shadow = (cfg_ch.data < WLEN_MIN) ? WLEN_MIN :
                                  (cfg_ch.data > WMAX) ? WMAX : int'(cfg_ch.data);
                    restart_shadow();
                end
            end
        end
    end

    // result receiver: random stalls plus one long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            result_ch.ready <= 1'b0;
            hold_taken      <= 1'b0;
            hold_left       <= 0;
        end else if (hold_req && !hold_taken) begin
            hold_taken      <= 1'b1;
            hold_left       <= 900;
            result_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left       <= hold_left - 1;
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // result checker: field by field against the oldest expectation
    always @(posedge clk) begin
        t_band_result exp_r;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            if (expected_bands.size() == 0) begin
                $error("unexpected result item");
                fails++;
            end else begin
                exp_r = expected_bands.pop_front();
                if (result_ch.window_full !== exp_r.window_full) begin
                    $error("window_full exp %0d got %0d", exp_r.window_full,
                           result_ch.window_full);
                    fails++;
                end
                if (result_ch.window_mean !== exp_r.window_mean) begin
                    $error("window_mean exp %0d got %0d", exp_r.window_mean,
                           result_ch.window_mean);
                    fails++;
                end
                if (result_ch.upper_band !== exp_r.upper_band) begin
                    $error("upper_band exp %0d got %0d", exp_r.upper_band,
                           result_ch.upper_band);
                    fails++;
                end
                if (result_ch.lower_band !== exp_r.lower_band) begin
                    $error("lower_band exp %0d got %0d", exp_r.lower_band,
                           result_ch.lower_band);
                    fails++;
                end
            end
        end
    end

    // wait until every item is sent and every band has come back, then settle
    task automatic drain();
        @(posedge clk);
        while (pending_prices.size() > 0 || price_ch.valid || expected_bands.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // mostly clustered prices so bands stay in range, some full-range noise
    function automatic logic [PBITS-1:0] rand_price(logic [PBITS-1:0] base);
        int spread;
        if ($urandom_range(3) == 0) return PBITS'($urandom);
        spread = 1 << $urandom_range(16);
        return base + PBITS'($urandom_range(spread)) - PBITS'(spread / 2);
    endfunction

    initial begin
        logic [PBITS-1:0] base;
        int n;
        fails          = 0;
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        hold_req       = 1'b0;
        mult_shadow    = MULT_RESET;
        wlen_shadow    = WLEN_RESET;
        restart_shadow();
        rst_n          <= 1'b0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= REG_BAND_MULT;
        cfg_ch.data    <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings, window fills from zero then full-scale
        pending_prices = '{24'd0, 24'hFF_FFFF, 24'd0, 24'hFF_FFFF, 24'h00_0100, 24'h12_3456};
        drain();
        // shortest window via a too-small length, widest multiplier: both bands saturate
        write_reg(REG_WINDOW_LEN, 8'd0);
        write_reg(REG_BAND_MULT, 8'hFF);
        pending_prices = '{24'd0, 24'hFF_FFFF, 24'hFF_FFFF, 24'd0, 24'd5};
        drain();
        // multiplier change keeps the window, zero multiplier collapses the bands
        write_reg(REG_BAND_MULT, 8'd0);
        pending_prices = '{24'hAB_CDEF, 24'h00_0001};
        drain();
        // length one clamps up, lengths above the maximum clamp down
        write_reg(REG_WINDOW_LEN, 8'd1);
        pending_prices = '{24'd7, 24'd9};
        drain();
        write_reg(REG_WINDOW_LEN, 8'hFF);
        // writes to indexes outside the register list are ignored
        write_reg(2'd2, 8'd3);
        write_reg(2'd3, 8'd0);
        write_reg(REG_BAND_MULT, 8'd32);
        for (int i = 0; i < 8; i++) pending_prices.push_back(rand_price(24'h40_0000));
        drain();

        // random phases, new settings between them
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_WINDOW_LEN, 8'd2);
                    write_reg(REG_BAND_MULT, 8'd24);
                end
                1: begin
                    write_reg(REG_WINDOW_LEN, 8'd32);
                    write_reg(REG_BAND_MULT, 8'hFF);
                end
                default: begin
                    write_reg(REG_WINDOW_LEN, 8'($urandom_range(40)));
                    write_reg(REG_BAND_MULT, 8'($urandom));
                end
            endcase
            tx_idle_pct = (ph < 2) ? 10 : (ph < 4) ? 65 : 0;
            rx_idle_pct = (ph < 2) ? 65 : (ph < 4) ? 10 : 0;
            // receiver blocks for a long stretch while items keep coming
            if (ph == 2) hold_req = 1'b1;
            base = PBITS'($urandom);
            n    = 0;
            while (n < 280) begin
                // sender pauses until everything is back now and then
                if (pending_prices.size() > 20) begin
                    @(posedge clk);
                end else begin
                    if ($urandom_range(15) == 0) base = PBITS'($urandom);
                    pending_prices.push_back(rand_price(base));
                    n++;
                    if (n == 140) drain();
                end
            end
            drain();
        end

        if (fails == 0 && expected_bands.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #30_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
sv/bbc_pkg.sv
sv/bbc_if.sv
sv/bbc_ram.sv
sv/bbc_mul.sv
sv/bbc_div.sv
sv/bbc_isqrt.sv
sv/bollinger_band_calculator.sv
sim/bollinger_band_calculator_tb.sv
